// ----- rtl/core/ldsfw_pkg.sv -----
// Shared types and constants for the LED digit shadow frame writer.
package ldsfw_pkg;

  // Number of digit positions driven; the shadow store holds eight entries.
  localparam int unsigned DigitCount  = 8;
  localparam int unsigned ShadowDepth = 8;
  localparam int unsigned CursorW     = $clog2(ShadowDepth);

  localparam logic [7:0] IntensityReset = 8'h0f;
  localparam logic [7:0] ScanLimit      = 8'd8;
  localparam logic [7:0] ScanClamped    = 8'd7;

  // Register addresses of the digit driver.
  localparam logic [3:0] AddrDecode    = 4'h9;
  localparam logic [3:0] AddrIntensity = 4'ha;
  localparam logic [3:0] AddrScan      = 4'hb;
  localparam logic [3:0] AddrOn        = 4'hc;
  localparam logic [3:0] AddrTest      = 4'hf;
  localparam logic [3:0] AddrDigitTop  = 4'h8;

  typedef enum logic [2:0] {
    ReqSetPos    = 3'd0,
    ReqWrite     = 3'd1,
    ReqClear     = 3'd2,
    ReqOn        = 3'd3,
    ReqTest      = 3'd4,
    ReqScan      = 3'd5,
    ReqIntensity = 3'd6,
    ReqDecode    = 3'd7
  } req_kind_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic       sends_frame;
    logic [3:0] reg_addr;
    logic [7:0] reg_data;
    logic       error;
    logic       last;
  } rsp_t;

endpackage

// ----- rtl/core/ldsfw_shadow_ram.sv -----
// Digit shadow store: one write port, one registered read port, per-entry valid bits.
module ldsfw_shadow_ram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ldsfw_pkg::CursorW-1:0]    waddr_i,
  input  logic [7:0]                       wdata_i,
  input  logic                             re_i,
  input  logic [ldsfw_pkg::CursorW-1:0]    raddr_i,
  output logic [7:0]                       rdata_o
);

  logic [7:0]                         mem_q [ldsfw_pkg::ShadowDepth];
  logic [ldsfw_pkg::ShadowDepth-1:0]  valid_q;
  logic [7:0]                         rdata_q;
  logic                               rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : 8'h00;

endmodule

// ----- rtl/core/led_digit_shadow_frame_writer.sv -----
// Top level of the LED digit shadow frame writer.
//
// This block turns display requests into 12-bit register frames (a 4-bit
// register address and an 8-bit data byte) for a serial seven-segment digit
// driver; it does not shift the bits out itself. Each accepted request
// transaction yields one or more result transactions, and the final one of a
// request carries last. Requests are handled one at a time. Set position, on,
// test, scan count, intensity and decode requests load the output register on
// acceptance, and the next request can follow as that result is taken. A
// write-digit request passes through the StDigit state, because the digit
// shadow lives in a synchronous RAM with a registered read port: the entry
// under the cursor is read when the request is accepted, and the compare,
// write-back and result follow in the next cycle. An accepted clear request
// sweeps the shadow RAM one entry per cycle while the result side is ready,
// one frame per entry. Results sit in an output register, so back-pressure
// on the result side simply holds the sequence where it is. The shadow
// starts from all zeros after reset without any clearing pass.
module led_digit_shadow_frame_writer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ldsfw_pkg::req_t in_req_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output ldsfw_pkg::rsp_t out_rsp_o
);

  typedef enum logic [1:0] {
    StIdle,
    StDigit,
    StClear
  } state_e;

  localparam int unsigned CW = ldsfw_pkg::CursorW;

  state_e            state_q, state_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     clr_idx_q, clr_idx_d;
  logic [7:0]        intensity_q, intensity_d;
  logic [7:0]        value_q, value_d;
  logic              out_valid_q, out_valid_d;
  ldsfw_pkg::rsp_t   out_rsp_q, out_rsp_d;

  logic              can_load;
  logic              in_fire;
  logic              ram_we;
  logic [CW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  logic [CW-1:0]     cursor_next;

  // The output register may be loaded when empty or when its result is
  // being taken in this very cycle.
  assign can_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && can_load;
  assign in_fire    = in_valid_i && in_ready_o;

  assign cursor_next = (cursor_q == CW'(ldsfw_pkg::DigitCount - 1)) ? '0
                                                                     : cursor_q + 1'b1;

  ldsfw_shadow_ram u_shadow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cursor_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cursor_d    = cursor_q;
    clr_idx_d   = clr_idx_q;
    intensity_d = intensity_q;
    value_d     = value_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rsp_d   = out_rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = cursor_q;
    ram_wdata   = value_q;
    ram_re      = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          value_d   = in_req_i.value;
          out_rsp_d = '{sends_frame: 1'b1, reg_addr: 4'h0, reg_data: in_req_i.value,
                        error: 1'b0, last: 1'b1};
          case (ldsfw_pkg::req_kind_e'(in_req_i.req_type))
            ldsfw_pkg::ReqSetPos: begin
              out_valid_d           = 1'b1;
              out_rsp_d.sends_frame = 1'b0;
              out_rsp_d.reg_data    = 8'h00;
              if (in_req_i.pos_y != 8'h00 ||
                  in_req_i.pos_x >= 8'(ldsfw_pkg::DigitCount)) begin
                out_rsp_d.error = 1'b1;
              end else begin
                cursor_d = in_req_i.pos_x[CW-1:0];
              end
            end
            ldsfw_pkg::ReqWrite: begin
              // Fetch the shadow entry under the cursor; compare next cycle.
              ram_re  = 1'b1;
              state_d = StDigit;
            end
            ldsfw_pkg::ReqClear: begin
              clr_idx_d = '0;
              state_d   = StClear;
            end
            ldsfw_pkg::ReqOn: begin
              out_valid_d        = 1'b1;
              out_rsp_d.reg_addr = ldsfw_pkg::AddrOn;
              out_rsp_d.reg_data = {7'd0, in_req_i.value != 8'h00};
            end
            ldsfw_pkg::ReqTest: begin
              out_valid_d        = 1'b1;
              out_rsp_d.reg_addr = ldsfw_pkg::AddrTest;
              out_rsp_d.reg_data = {7'd0, in_req_i.value != 8'h00};
            end
            ldsfw_pkg::ReqScan: begin
              out_valid_d        = 1'b1;
              out_rsp_d.reg_addr = ldsfw_pkg::AddrScan;
              if (in_req_i.value > ldsfw_pkg::ScanLimit) begin
                out_rsp_d.reg_data = ldsfw_pkg::ScanClamped;
                out_rsp_d.error    = 1'b1;
              end else begin
                // A count of zero wraps round to 255.
                out_rsp_d.reg_data = in_req_i.value - 8'd1;
              end
            end
            ldsfw_pkg::ReqIntensity: begin
              out_valid_d = 1'b1;
              if (in_req_i.value != intensity_q) begin
                intensity_d        = in_req_i.value;
                out_rsp_d.reg_addr = ldsfw_pkg::AddrIntensity;
              end else begin
                out_rsp_d.sends_frame = 1'b0;
                out_rsp_d.reg_data    = 8'h00;
              end
            end
            ldsfw_pkg::ReqDecode: begin
              out_valid_d        = 1'b1;
              out_rsp_d.reg_addr = ldsfw_pkg::AddrDecode;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      StDigit: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (value_q != ram_rdata) begin
            ram_we    = 1'b1;
            ram_waddr = cursor_q;
            ram_wdata = value_q;
            out_rsp_d = '{sends_frame: 1'b1,
                          reg_addr: ldsfw_pkg::AddrDigitTop - {1'b0, cursor_q},
                          reg_data: value_q, error: 1'b0, last: 1'b1};
          end else begin
            out_rsp_d = '{sends_frame: 1'b0, reg_addr: 4'h0, reg_data: 8'h00,
                          error: 1'b0, last: 1'b1};
          end
          cursor_d = cursor_next;
          state_d  = StIdle;
        end
      end

      StClear: begin
        if (can_load) begin
          ram_we      = 1'b1;
          ram_waddr   = clr_idx_q;
          ram_wdata   = 8'h00;
          out_valid_d = 1'b1;
          out_rsp_d   = '{sends_frame: 1'b1,
                          reg_addr: {1'b0, clr_idx_q} + 4'd1,
                          reg_data: 8'h00, error: 1'b0,
                          last: clr_idx_q == CW'(ldsfw_pkg::ShadowDepth - 1)};
          if (clr_idx_q == CW'(ldsfw_pkg::ShadowDepth - 1)) begin
            state_d = StIdle;
          end else begin
            clr_idx_d = clr_idx_q + 1'b1;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cursor_q    <= '0;
      clr_idx_q   <= '0;
      intensity_q <= ldsfw_pkg::IntensityReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      clr_idx_q   <= clr_idx_d;
      intensity_q <= intensity_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    value_q   <= value_d;
    out_rsp_q <= out_rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// ----- tb/ldsfw_frame_checker.sv -----
// Scoreboard for the LED digit shadow frame writer: predicts and checks frames.
`timescale 1ns / 100ps

module ldsfw_frame_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  ldsfw_pkg::req_t in_req_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  ldsfw_pkg::rsp_t out_rsp_i,
  output int unsigned     mismatch_count_o,
  output int unsigned     frames_pending_o,
  output int unsigned     frames_checked_o
);

  logic [7:0]                    shadow_q [ldsfw_pkg::ShadowDepth];
  logic [ldsfw_pkg::CursorW-1:0] cursor_q;
  logic [7:0]                    intensity_q;
  ldsfw_pkg::rsp_t               frames_due [$];
  int unsigned                   mismatches;
  int unsigned                   checked;

  function automatic ldsfw_pkg::rsp_t make_frame(input logic send, input logic [3:0] addr,
                                                 input logic [7:0] data, input logic err,
                                                 input logic fin);
    ldsfw_pkg::rsp_t f;
    f.sends_frame = send;
    f.reg_addr    = send ? addr : 4'h0;
    f.reg_data    = send ? data : 8'h00;
    f.error       = err;
    f.last        = fin;
    return f;
  endfunction

  // Works out the frames one request transaction gives and moves the shadow state on.
  task automatic predict_frames(input ldsfw_pkg::req_t r);
    case (ldsfw_pkg::req_kind_e'(r.req_type))
      ldsfw_pkg::ReqSetPos: begin
        if (r.pos_y != 8'h00 || r.pos_x >= ldsfw_pkg::DigitCount) begin
          frames_due.push_back(make_frame(1'b0, 4'h0, 8'h00, 1'b1, 1'b1));
        end else begin
          cursor_q = r.pos_x[ldsfw_pkg::CursorW-1:0];
          frames_due.push_back(make_frame(1'b0, 4'h0, 8'h00, 1'b0, 1'b1));
        end
      end
      ldsfw_pkg::ReqWrite: begin
        if (r.value != shadow_q[cursor_q]) begin
          shadow_q[cursor_q] = r.value;
          frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrDigitTop - 4'(cursor_q),
                                          r.value, 1'b0, 1'b1));
        end else begin
          frames_due.push_back(make_frame(1'b0, 4'h0, 8'h00, 1'b0, 1'b1));
        end
        if (cursor_q == ldsfw_pkg::CursorW'(ldsfw_pkg::DigitCount - 1)) cursor_q = '0;
        else cursor_q = cursor_q + 1'b1;
      end
      ldsfw_pkg::ReqClear: begin
        for (int i = 0; i < ldsfw_pkg::ShadowDepth; i++) begin
          shadow_q[i] = 8'h00;
          frames_due.push_back(make_frame(1'b1, 4'(i + 1), 8'h00, 1'b0,
                                          i == ldsfw_pkg::ShadowDepth - 1));
        end
      end
      ldsfw_pkg::ReqOn:
        frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrOn, {7'b0, |r.value},
                                        1'b0, 1'b1));
      ldsfw_pkg::ReqTest:
        frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrTest, {7'b0, |r.value},
                                        1'b0, 1'b1));
      ldsfw_pkg::ReqScan: begin
        if (r.value > ldsfw_pkg::ScanLimit) begin
          frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrScan, ldsfw_pkg::ScanClamped,
                                          1'b1, 1'b1));
        end else begin
          frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrScan, r.value - 8'd1,
                                          1'b0, 1'b1));
        end
      end
      ldsfw_pkg::ReqIntensity: begin
        if (r.value != intensity_q) begin
          intensity_q = r.value;
          frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrIntensity, r.value,
                                          1'b0, 1'b1));
        end else begin
          frames_due.push_back(make_frame(1'b0, 4'h0, 8'h00, 1'b0, 1'b1));
        end
      end
      ldsfw_pkg::ReqDecode:
        frames_due.push_back(make_frame(1'b1, ldsfw_pkg::AddrDecode, r.value, 1'b0, 1'b1));
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ldsfw_pkg::rsp_t want;
    if (!rst_ni) begin
      foreach (shadow_q[i]) shadow_q[i] = 8'h00;
      cursor_q    = '0;
      intensity_q = ldsfw_pkg::IntensityReset;
      frames_due.delete();
      mismatches  = 0;
      checked     = 0;
    end else begin
      // A request is predicted before the result side is looked at, so a result
      // handed over in the same cycle as its request still finds its entry.
      if (in_valid_i && in_ready_i) predict_frames(in_req_i);
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_rsp_i);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          check_field("sends_frame", 8'(want.sends_frame), 8'(out_rsp_i.sends_frame));
          check_field("reg_addr", 8'(want.reg_addr), 8'(out_rsp_i.reg_addr));
          check_field("reg_data", want.reg_data, out_rsp_i.reg_data);
          check_field("error", 8'(want.error), 8'(out_rsp_i.error));
          check_field("last", 8'(want.last), 8'(out_rsp_i.last));
        end
      end
    end
    mismatch_count_o <= mismatches;
    frames_pending_o <= frames_due.size();
    frames_checked_o <= checked;
  end

endmodule

// ----- tb/tb_led_digit_shadow_frame_writer.sv -----
// Testbench top for the LED digit shadow frame writer: stimulus and verdict.
`timescale 1ns / 100ps

module tb_led_digit_shadow_frame_writer;

  // The slowest correct run is far shorter than the limit: about 100 requests,
  // at most eight results each, every result possibly held up by the receiver.
  // The limit leaves a wide margin above that.
  localparam int unsigned CycleLimit  = 60000;
  localparam int unsigned RandomItems = 75;
  // A clear request gives the longest run of results, so this many quiet
  // cycles at the end are ample to catch any stray result.
  localparam int unsigned DrainCycles = 24;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready_o;
  ldsfw_pkg::req_t in_req    = '0;
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  ldsfw_pkg::rsp_t out_rsp_o;

  int unsigned mismatch_count;
  int unsigned frames_pending;
  int unsigned frames_checked;
  int unsigned requests_sent = 0;
  int unsigned cycle_count   = 0;
  int unsigned stall_left    = 0;
  // When clear, neither side inserts idle cycles.
  logic        idle_on       = 1'b1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  led_digit_shadow_frame_writer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  ldsfw_frame_checker i_frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready_o),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready),
    .out_rsp_i       (out_rsp_o),
    .mismatch_count_o(mismatch_count),
    .frames_pending_o(frames_pending),
    .frames_checked_o(frames_checked)
  );

  // The result side stalls in bursts of random length, entered at random,
  // so that back-pressure lands on every step of a multi-frame sequence.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, frames_pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Presents one request transaction and holds it until the block takes it.
  // An optional idle burst comes first; when there is none, valid simply stays
  // high from the previous transaction, so it gets one assignment per step.
  task automatic send_request(input ldsfw_pkg::req_kind_e kind, input logic [7:0] x,
                              input logic [7:0] y, input logic [7:0] v);
    ldsfw_pkg::req_t r;
    r.req_type = kind;
    r.pos_x    = x;
    r.pos_y    = y;
    r.value    = v;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    // Everything is driven with nonblocking assignments, so the ready seen here
    // is the one that held at the edge just passed.
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  initial begin
    int unsigned          pick;
    logic [7:0]           val;
    logic [7:0]           px;
    logic [7:0]           py;
    ldsfw_pkg::req_kind_e kind;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Intensity first: the reset value gives no frame, as does
    // repeating a value just sent.
    send_request(ldsfw_pkg::ReqIntensity, 8'h00, 8'h00, 8'h0f);
    send_request(ldsfw_pkg::ReqIntensity, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqIntensity, 8'h00, 8'h00, 8'hff);
    send_request(ldsfw_pkg::ReqIntensity, 8'h00, 8'h00, 8'hff);
    // Writing zero over a freshly reset shadow is suppressed but still moves
    // the cursor on.
    send_request(ldsfw_pkg::ReqWrite, 8'h00, 8'h00, 8'h00);
    // The last column maps to the lowest digit register, and the cursor then
    // wraps round to column zero.
    send_request(ldsfw_pkg::ReqSetPos, 8'h07, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqWrite, 8'h00, 8'h00, 8'hff);
    send_request(ldsfw_pkg::ReqWrite, 8'h00, 8'h00, 8'h80);
    // Rejected positions: column just past the end, a non-zero row, and both
    // at their maximum.
    send_request(ldsfw_pkg::ReqSetPos, 8'h08, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqSetPos, 8'h00, 8'h01, 8'h00);
    send_request(ldsfw_pkg::ReqSetPos, 8'hff, 8'hff, 8'hff);
    // After a clear, writing zero anywhere is redundant.
    send_request(ldsfw_pkg::ReqClear, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqSetPos, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqWrite, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqOn, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqOn, 8'h00, 8'h00, 8'h80);
    send_request(ldsfw_pkg::ReqTest, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqTest, 8'h00, 8'h00, 8'hff);
    // Scan count: zero wraps to 255, eight is the top legal value, and
    // anything above is clamped with the error flag.
    send_request(ldsfw_pkg::ReqScan, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqScan, 8'h00, 8'h00, 8'h01);
    send_request(ldsfw_pkg::ReqScan, 8'h00, 8'h00, 8'h08);
    send_request(ldsfw_pkg::ReqScan, 8'h00, 8'h00, 8'h09);
    send_request(ldsfw_pkg::ReqScan, 8'h00, 8'h00, 8'hff);
    send_request(ldsfw_pkg::ReqDecode, 8'h00, 8'h00, 8'h00);
    send_request(ldsfw_pkg::ReqDecode, 8'h00, 8'h00, 8'hff);

    // Random part. Digit writes and cursor moves dominate, since the shadow
    // compare and cursor wrap are where the state lives. Values are drawn from
    // a narrow pool often enough that redundant writes are common. A window in
    // the middle and the final stretch run without any idling.
    for (int n = 0; n < RandomItems; n++) begin
      idle_on = !(n >= 30 && n < 45) && (n < RandomItems - 20);
      pick = $urandom_range(0, 99);
      px   = 8'($urandom);
      py   = 8'($urandom);
      case ($urandom_range(0, 3))
        0:       val = 8'h00;
        1:       val = 8'hff;
        default: val = 8'($urandom);
      endcase
      if (pick < 35) begin
        kind = ldsfw_pkg::ReqWrite;
      end else if (pick < 55) begin
        kind = ldsfw_pkg::ReqSetPos;
        px   = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(8, 255))
                                           : 8'($urandom_range(0, 7));
        py   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      end else if (pick < 62) begin
        kind = ldsfw_pkg::ReqClear;
      end else if (pick < 72) begin
        kind = ldsfw_pkg::ReqIntensity;
        if ($urandom_range(0, 3) != 0) val = 8'($urandom_range(14, 16));
      end else if (pick < 80) begin
        kind = ldsfw_pkg::ReqScan;
        if ($urandom_range(0, 3) != 0) val = 8'($urandom_range(0, 10));
      end else if (pick < 87) begin
        kind = ldsfw_pkg::ReqOn;
      end else if (pick < 94) begin
        kind = ldsfw_pkg::ReqTest;
      end else begin
        kind = ldsfw_pkg::ReqDecode;
      end
      send_request(kind, px, py, val);
    end
    in_valid <= 1'b0;

    // Let the block drain, then give it a quiet spell to show nothing extra.
    while (frames_pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Drove %0d requests of all eight kinds, with stalls on both sides;",
             requests_sent);
    $display("checked %0d results against the predicted frames.", frames_checked);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- led_digit_shadow_frame_writer.f -----
rtl/core/ldsfw_pkg.sv
rtl/core/ldsfw_shadow_ram.sv
rtl/core/led_digit_shadow_frame_writer.sv
tb/ldsfw_frame_checker.sv
tb/tb_led_digit_shadow_frame_writer.sv
